@@ rtl/core/fbab_pkg.sv @@
// ============================================================================
// fbab_pkg: shared types and constants for the framebuffer alpha blender
// Holds the input and result transaction types, the command record that the
// front hands to the back, the operation codes and the back sequencer states.
// ============================================================================
`default_nettype none

package fbab_pkg;

    // Default frame geometry, in pixels.
    localparam int FRAME_WIDTH_DEF  = 1024;
    localparam int FRAME_HEIGHT_DEF = 768;

    // Depth of the command queue between front and back.
    localparam int QUEUE_DEPTH_DEF = 2;

    // Address width of a command; covers the largest frame (2048 x 2048).
    localparam int CMD_ADDR_W = 22;

    // Operation codes.
    typedef enum logic [0:0] {
        FUNC_BLEND = 1'b0,
        FUNC_READ  = 1'b1
    } func_t;

    // One input transaction.
    typedef struct packed {
        func_t              func;
        logic signed [11:0] x_pos;
        logic signed [11:0] y_pos;
        logic [7:0]         src_red;
        logic [7:0]         src_green;
        logic [7:0]         src_blue;
        logic [7:0]         src_alpha;
    } in_item_t;

    // One result transaction.
    typedef struct packed {
        logic [31:0] pixel_word;
        logic        in_frame;
    } out_item_t;

    // Classified command, as queued between front and back.
    typedef struct packed {
        func_t                 func;
        logic                  in_frame;
        logic [CMD_ADDR_W-1:0] addr;
        logic [7:0]            src_red;
        logic [7:0]            src_green;
        logic [7:0]            src_blue;
        logic [7:0]            src_alpha;
    } cmd_t;

    // Back sequencer: fetch, five arithmetic steps, store.
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_READ,
        BK_MIX1,
        BK_MIX2,
        BK_MIX3,
        BK_MIX4,
        BK_MIX5,
        BK_STORE
    } back_state_t;

endpackage

`default_nettype wire

@@ rtl/core/fbab_front.sv @@
// ============================================================================
// fbab_front: input stage of the framebuffer alpha blender
// Accepts transactions, checks the coordinates against the frame, forms the
// linear word address and holds the command until the queue takes it.
// ============================================================================
`default_nettype none

module fbab_front #(
    parameter int FRAME_WIDTH  = fbab_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = fbab_pkg::FRAME_HEIGHT_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              take,
    input  wire fbab_pkg::in_item_t item,
    input  wire logic              q_full,
    output logic                   q_push,
    output fbab_pkg::cmd_t         q_cmd,
    output logic                   busy
);

    logic           cmd_valid_reg;
    logic           cmd_valid_next;
    fbab_pkg::cmd_t cmd_reg;
    fbab_pkg::cmd_t cmd_next;

    logic [10:0] xu;
    logic [10:0] yu;
    logic        x_ok;
    logic        y_ok;
    logic [23:0] lin_addr;

    // Coordinate check and linear address.
    always_comb
    begin
        xu       = item.x_pos[10:0];
        yu       = item.y_pos[10:0];
        x_ok     = !item.x_pos[11] && (13'(xu) < 13'(FRAME_WIDTH));
        y_ok     = !item.y_pos[11] && (13'(yu) < 13'(FRAME_HEIGHT));
        lin_addr = 24'(yu) * 24'(FRAME_WIDTH) + 24'(xu);

        cmd_next.func      = item.func;
        cmd_next.in_frame  = x_ok && y_ok;
        cmd_next.addr      = (x_ok && y_ok) ? lin_addr[fbab_pkg::CMD_ADDR_W-1:0] : '0;
        cmd_next.src_red   = item.src_red;
        cmd_next.src_green = item.src_green;
        cmd_next.src_blue  = item.src_blue;
        cmd_next.src_alpha = item.src_alpha;
    end

    // The held command moves on whenever the queue has room.
    assign q_push         = cmd_valid_reg && !q_full;
    assign busy           = cmd_valid_reg && q_full;
    assign q_cmd          = cmd_reg;
    assign cmd_valid_next = take || (cmd_valid_reg && q_full);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
        end
    end

    // Command payload.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/fbab_queue.sv @@
// ============================================================================
// fbab_queue: command queue between front and back
// A small first-in first-out buffer of classified commands, so that the
// front keeps accepting while the back works on an earlier pixel.
// ============================================================================
`default_nettype none

module fbab_queue #(
    parameter int DEPTH = fbab_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire fbab_pkg::cmd_t push_cmd,
    output logic                full,
    input  wire logic           pop,
    output fbab_pkg::cmd_t      head_cmd,
    output logic                empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    fbab_pkg::cmd_t   slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign head_cmd = slot_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue slots.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/fbab_back.sv @@
// ============================================================================
// fbab_back: frame store and blend engine
// Owns the frame memory and its clearing pass, fetches the destination word
// for each command, runs the over operator in five registered steps, writes
// a blended word back and holds the result until it is taken.
// ============================================================================
`default_nettype none

module fbab_back #(
    parameter int FRAME_WIDTH  = fbab_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = fbab_pkg::FRAME_HEIGHT_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_empty,
    input  wire fbab_pkg::cmd_t q_cmd,
    output logic                q_pop,
    input  wire logic           pop,
    output logic                empty,
    output fbab_pkg::out_item_t result,
    output logic                clearing
);

    localparam int DEPTH  = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    // Floor of 5*a/6 by a scaled reciprocal; exact for all 8-bit a.
    function automatic logic [7:0] weaken_alpha(input logic [7:0] a);
        logic [19:0] p;
        p = 20'(a) * 20'(3415);
        return p[19:12];
    endfunction

    // Floor of n/255: reciprocal estimate, then one correction step.
    function automatic logic [16:0] div255(input logic [23:0] n);
        logic [40:0] acc;
        logic [16:0] q0;
        logic [24:0] rem;
        acc = 41'(n) + (41'(n) << 8) + (41'(n) << 16);
        q0  = acc[40:24];
        rem = 25'(n) - ((25'(q0) << 8) - 25'(q0));
        if (rem >= 25'(255))
        begin
            q0 = q0 + 17'(1);
        end
        return q0;
    endfunction

    // Frame memory and its read register.
    logic [31:0]       frame_mem [DEPTH];
    logic [31:0]       rd_data_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [31:0]       mem_wdata;
    logic [ADDR_W-1:0] rd_addr;

    // Clearing pass.
    logic              clr_active_reg;
    logic              clr_active_next;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [ADDR_W-1:0] clr_addr_next;

    // Sequencer and result slot.
    fbab_pkg::back_state_t state_reg;
    fbab_pkg::back_state_t state_next;
    logic                  res_load;
    logic                  store_we;
    logic                  res_valid_reg;
    logic                  res_valid_next;
    fbab_pkg::out_item_t   res_reg;

    // Datapath.
    fbab_pkg::cmd_t   cur_reg;
    logic [31:0]      dst_reg;
    logic [7:0]       w_reg;
    logic [2:0][15:0] ps_reg;
    logic [15:0]      t_reg;
    logic [2:0][7:0]  qs_reg;
    logic [2:0][23:0] n_reg;
    logic [7:0]       na_reg;
    logic [2:0][15:0] m_reg;
    logic [31:0]      word_reg;

    logic [2:0][7:0]  src_ch;
    logic [2:0][7:0]  dst_ch;
    logic [7:0]       inv_sa;
    logic [2:0][16:0] qs_full;
    logic [2:0][16:0] m_full;
    logic [2:0][16:0] tail_full;
    logic [16:0]      ta_full;
    logic [2:0][7:0]  chan;
    logic [31:0]      word_sel;

    assign clearing = clr_active_reg;
    assign empty    = !res_valid_reg;
    assign result   = res_reg;

    // Clearing pass: one word per cycle from address zero after reset.
    assign clr_active_next = clr_active_reg && (clr_addr_reg != LAST_ADDR);
    assign clr_addr_next   = clr_active_reg ? clr_addr_reg + ADDR_W'(1) : clr_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            state_reg      <= fbab_pkg::BK_IDLE;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
            state_reg      <= state_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fbab_pkg::BK_IDLE:
            begin
                if (!clr_active_reg && !q_empty)
                begin
                    state_next = fbab_pkg::BK_READ;
                end
            end
            fbab_pkg::BK_READ:  state_next = fbab_pkg::BK_MIX1;
            fbab_pkg::BK_MIX1:  state_next = fbab_pkg::BK_MIX2;
            fbab_pkg::BK_MIX2:  state_next = fbab_pkg::BK_MIX3;
            fbab_pkg::BK_MIX3:  state_next = fbab_pkg::BK_MIX4;
            fbab_pkg::BK_MIX4:  state_next = fbab_pkg::BK_MIX5;
            fbab_pkg::BK_MIX5:  state_next = fbab_pkg::BK_STORE;
            fbab_pkg::BK_STORE:
            begin
                if (!res_valid_reg || pop)
                begin
                    state_next = fbab_pkg::BK_IDLE;
                end
            end
            default:            state_next = fbab_pkg::BK_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        q_pop    = 1'b0;
        res_load = 1'b0;
        store_we = 1'b0;
        case (state_reg)
            fbab_pkg::BK_IDLE:
            begin
                q_pop = !clr_active_reg && !q_empty;
            end
            fbab_pkg::BK_STORE:
            begin
                res_load = !res_valid_reg || pop;
                store_we = res_load && cur_reg.in_frame
                           && (cur_reg.func == fbab_pkg::FUNC_BLEND);
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    // Result slot: filled at the end of an item, emptied by a pop.
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (pop && res_valid_reg)
        begin
            res_valid_next = 1'b0;
        end
    end

    // Memory port selection: the clearing pass owns the write port while active.
    always_comb
    begin
        mem_we    = clr_active_reg || store_we;
        mem_waddr = clr_active_reg ? clr_addr_reg : cur_reg.addr[ADDR_W-1:0];
        mem_wdata = clr_active_reg ? 32'd0 : word_reg;
        rd_addr   = cur_reg.addr[ADDR_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            frame_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= frame_mem[rd_addr];
    end

    // Channel views and the divisions of each step.
    always_comb
    begin
        src_ch = {cur_reg.src_red, cur_reg.src_green, cur_reg.src_blue};
        dst_ch = dst_reg[31:8];
        inv_sa = ~cur_reg.src_alpha;
        ta_full = div255(24'(t_reg));
        for (int c = 0; c < 3; c++)
        begin
            qs_full[c]   = div255(24'(ps_reg[c]));
            m_full[c]    = div255(n_reg[c]);
            tail_full[c] = div255(24'(m_reg[c]));
            chan[c]      = qs_reg[c] + tail_full[c][7:0];
        end
    end

    // Final word: zero out of frame, stored word on a read, source on an
    // empty destination, blended word otherwise.
    always_comb
    begin
        if (!cur_reg.in_frame)
        begin
            word_sel = 32'd0;
        end
        else if (cur_reg.func == fbab_pkg::FUNC_READ)
        begin
            word_sel = dst_reg;
        end
        else if (dst_reg == 32'd0)
        begin
            word_sel = {cur_reg.src_red, cur_reg.src_green, cur_reg.src_blue,
                        cur_reg.src_alpha};
        end
        else
        begin
            word_sel = {chan[2], chan[1], chan[0], na_reg};
        end
    end

    // Datapath registers, one step per sequencer state.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_cmd;
        end
        case (state_reg)
            fbab_pkg::BK_MIX1:
            begin
                dst_reg <= rd_data_reg;
                w_reg   <= weaken_alpha(rd_data_reg[7:0]);
                for (int c = 0; c < 3; c++)
                begin
                    ps_reg[c] <= 16'(src_ch[c]) * 16'(cur_reg.src_alpha);
                end
            end
            fbab_pkg::BK_MIX2:
            begin
                t_reg <= 16'(w_reg) * 16'(inv_sa);
                for (int c = 0; c < 3; c++)
                begin
                    qs_reg[c] <= qs_full[c][7:0];
                end
            end
            fbab_pkg::BK_MIX3:
            begin
                na_reg <= cur_reg.src_alpha + ta_full[7:0];
                for (int c = 0; c < 3; c++)
                begin
                    n_reg[c] <= 24'(dst_ch[c]) * 24'(t_reg);
                end
            end
            fbab_pkg::BK_MIX4:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    m_reg[c] <= m_full[c][15:0];
                end
            end
            fbab_pkg::BK_MIX5:
            begin
                word_reg <= word_sel;
            end
            default:
            begin
                if (res_load)
                begin
                    res_reg.pixel_word <= word_reg;
                    res_reg.in_frame   <= cur_reg.in_frame;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/framebuffer_alpha_blend.sv @@
// ============================================================================
// framebuffer_alpha_blend: RGBA8888 over-operator compositing into a frame
// Blends source pixels into a cleared frame store or reads stored words back.
// ============================================================================
//
// Channel   Direction  Handshake            Payload
// item      in         push / full          fbab_pkg::in_item_t
// result    out        empty / pop          fbab_pkg::out_item_t
//
// The back sequencer handles one pixel at a time: command fetch, memory read, five
// arithmetic steps and the write-back, before it fetches the next command.
// After reset, full stays high while the frame store is cleared one word per cycle,
// FRAME_WIDTH*FRAME_HEIGHT words in all (786432 by default).
// The front and the command queue keep accepting up to QUEUE_DEPTH+1 items
// while the back works; an untaken result holds the back in its store step.
// ============================================================================
`default_nettype none

module framebuffer_alpha_blend #(
    parameter int FRAME_WIDTH  = fbab_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = fbab_pkg::FRAME_HEIGHT_DEF,
    parameter int QUEUE_DEPTH  = fbab_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire fbab_pkg::in_item_t  item,
    output logic                     full,
    input  wire logic                pop,
    output fbab_pkg::out_item_t      result,
    output logic                     empty
);

    logic           take;
    logic           front_busy;
    logic           clearing;
    logic           q_push;
    logic           q_full;
    logic           q_pop;
    logic           q_empty;
    fbab_pkg::cmd_t front_cmd;
    fbab_pkg::cmd_t head_cmd;

    // Input is held off while the front is blocked or the store is clearing.
    assign full = front_busy || clearing;
    assign take = push && !full;

    fbab_front #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (take),
        .item   (item),
        .q_full (q_full),
        .q_push (q_push),
        .q_cmd  (front_cmd),
        .busy   (front_busy)
    );

    fbab_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (front_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .empty    (q_empty)
    );

    fbab_back #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_cmd    (head_cmd),
        .q_pop    (q_pop),
        .pop      (pop),
        .empty    (empty),
        .result   (result),
        .clearing (clearing)
    );

endmodule

`default_nettype wire

@@ rtl/core/fbab_checker.sv @@
// ============================================================================
// fbab_checker: port-level checks for the framebuffer alpha blender
// Watches the two queue-style channels and tracks transactions in flight.
// ============================================================================
`default_nettype none

module fbab_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                push,
    input wire fbab_pkg::in_item_t  item,
    input wire logic                full,
    input wire logic                pop,
    input wire fbab_pkg::out_item_t result,
    input wire logic                empty
);

    logic [7:0] in_flight_reg;
    logic [7:0] in_flight_next;
    logic       acc_in;
    logic       acc_out;

    assign acc_in  = push && !full;
    assign acc_out = pop && !empty;

    // Transactions accepted but not yet delivered.
    always_comb
    begin
        in_flight_next = in_flight_reg;
        if (acc_in && !acc_out)
        begin
            in_flight_next = in_flight_reg + 8'd1;
        end
        else if (acc_out && !acc_in)
        begin
            in_flight_next = in_flight_reg - 8'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_flight_reg <= 8'd0;
        end
        else
        begin
            in_flight_reg <= in_flight_next;
        end
    end

    // A waiting result that is not taken stays unchanged.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("result changed while waiting");

    // No result appears without an earlier accepted transaction.
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (in_flight_reg != 8'd0))
        else $error("result without a pending transaction");

    // An out-of-frame answer carries a zero word.
    a_out_of_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result.in_frame) |-> (result.pixel_word == 32'd0))
        else $error("out-of-frame result with nonzero word");

    // Right after reset the store is being cleared and nothing is pending.
    a_reset_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> (full && empty))
        else $error("input open or result present right after reset");

endmodule

bind framebuffer_alpha_blend fbab_checker u_fbab_checker (.*);

`default_nettype wire

@@ sim/framebuffer_alpha_blend_checker.sv @@
// ============================================================================
// framebuffer_alpha_blend_checker: result predictor and comparator
// Watches the item and result channels of the alpha blender. Every accepted
// item is run through a shadow frame store to form the expected result word,
// and every accepted result is compared with the oldest expected one.
// ============================================================================
`default_nettype none

module framebuffer_alpha_blend_checker #(
    parameter int FRAME_WIDTH  = fbab_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = fbab_pkg::FRAME_HEIGHT_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire fbab_pkg::in_item_t  item,
    input  wire logic                full,
    input  wire logic                pop,
    input  wire fbab_pkg::out_item_t result,
    input  wire logic                empty,
    output int                       mismatches,
    output int                       pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import fbab_pkg::*;

    // Shadow copy of the frame; an address that was never written reads zero.
    logic [31:0] shadow_frame [int unsigned];
    out_item_t   expected_pixels [$];
    int          fails = 0;

    assign mismatches = fails;

    // One color channel of the over operator, with a weakened stored alpha.
    function automatic logic [7:0] over_channel(int unsigned s, int unsigned sa,
                                                int unsigned d, int unsigned w);
        int unsigned v;
        v = (s * sa) / 255 + (d * w * (255 - sa)) / 65025;
        return v[7:0];
    endfunction

    // New stored word after blending a source pixel over the stored word.
    function automatic logic [31:0] blended_word(logic [31:0] dst, in_item_t src);
        int unsigned w;
        int unsigned sa;
        int unsigned na;
        sa = src.src_alpha;
        if (dst == 32'd0)
            return {src.src_red, src.src_green, src.src_blue, src.src_alpha};
        w  = (dst[7:0] * 5) / 6;
        na = sa + (w * (255 - sa)) / 255;
        return {over_channel(src.src_red,   sa, dst[31:24], w),
                over_channel(src.src_green, sa, dst[23:16], w),
                over_channel(src.src_blue,  sa, dst[15:8],  w),
                na[7:0]};
    endfunction

    // Apply one item to the shadow frame and return the result it must give.
    function automatic out_item_t predict_pixel(in_item_t src);
        out_item_t   res;
        int          col;
        int          row;
        int unsigned addr;
        logic [31:0] stored;
        col = $signed(src.x_pos);
        row = $signed(src.y_pos);
        res = '0;
        if (col < 0 || row < 0 || col >= FRAME_WIDTH || row >= FRAME_HEIGHT)
            return res;
        addr   = row * FRAME_WIDTH + col;
        stored = shadow_frame.exists(addr) ? shadow_frame[addr] : 32'd0;
        if (src.func == FUNC_BLEND)
        begin
            stored             = blended_word(stored, src);
            shadow_frame[addr] = stored;
        end
        res.pixel_word = stored;
        res.in_frame   = 1'b1;
        return res;
    endfunction

    // Results are handled before items at the same edge: a result can never
    // belong to an item accepted at that very edge.
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (expected_pixels.size() == 0)
                begin
                    fails = fails + 1;
                    $error("unexpected result transaction: pixel_word %h in_frame %b",
                           result.pixel_word, result.in_frame);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (result.pixel_word !== want.pixel_word)
                    begin
                        fails = fails + 1;
                        $error("pixel_word mismatch: expected %h, actual %h",
                               want.pixel_word, result.pixel_word);
                    end
                    if (result.in_frame !== want.in_frame)
                    begin
                        fails = fails + 1;
                        $error("in_frame mismatch: expected %b, actual %b",
                               want.in_frame, result.in_frame);
                    end
                end
            end
            if (push && !full)
                expected_pixels.push_back(predict_pixel(item));
        end
        pending <= expected_pixels.size();
    end

endmodule

`default_nettype wire

@@ sim/framebuffer_alpha_blend_test.sv @@
// ============================================================================
// framebuffer_alpha_blend_test: top level of the alpha blender testbench
// Drives blend and read transactions into the block, first a directed set of
// corner cases and then a random mix concentrated on a small patch of pixels
// so that blends stack up, with random gaps on both channels.
// ============================================================================
`default_nettype none

module framebuffer_alpha_blend_test;
    timeunit 1ns;
    timeprecision 1ps;

    import fbab_pkg::*;

    localparam int FB_W         = FRAME_WIDTH_DEF;
    localparam int FB_H         = FRAME_HEIGHT_DEF;
    localparam int CLK_PERIOD   = 8;
    localparam int RANDOM_ITEMS = 550;
    // The clearing pass after reset, then ample room for every transaction.
    localparam int CYCLE_LIMIT  = FB_W * FB_H + 150_000;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      push;
    logic      full;
    logic      pop;
    logic      empty;
    in_item_t  item;
    out_item_t result;
    int        mismatches;
    int        pending;
    int        cycle_count = 0;

    // Runs of calm (no gaps) and busy phases on each side.
    bit        tx_calm = 1'b0;
    int        tx_calm_left = 0;
    bit        rx_calm = 1'b0;
    int        rx_calm_left = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    framebuffer_alpha_blend dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .item   (item),
        .full   (full),
        .pop    (pop),
        .result (result),
        .empty  (empty)
    );

    framebuffer_alpha_blend_checker #(
        .FRAME_WIDTH  (FB_W),
        .FRAME_HEIGHT (FB_H)
    ) result_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .item       (item),
        .full       (full),
        .pop        (pop),
        .result     (result),
        .empty      (empty),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic in_item_t make_item(func_t f, int x, int y, logic [31:0] rgba);
        in_item_t it;
        it.func      = f;
        it.x_pos     = x[11:0];
        it.y_pos     = y[11:0];
        it.src_red   = rgba[31:24];
        it.src_green = rgba[23:16];
        it.src_blue  = rgba[15:8];
        it.src_alpha = rgba[7:0];
        return it;
    endfunction

    // Offer one transaction after a random gap and hold it until accepted.
    // Called and returning at a rising edge; push stays high on return.
    task automatic send_item(in_item_t it);
        int gap;
        if (tx_calm_left == 0)
        begin
            tx_calm      = ($urandom_range(0, 2) == 0);
            tx_calm_left = $urandom_range(10, 40);
        end
        tx_calm_left = tx_calm_left - 1;
        gap = tx_calm ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        item <= it;
        do
            @(posedge clk);
        while (full);
    endtask

    // Stop offering and wait until every expected result has been taken.
    task automatic drain_results();
        push <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // Corner cases: empty frame, zero alpha, opaque writes, frame edges and
    // coordinate extremes on both axes.
    task automatic run_directed();
        send_item(make_item(FUNC_READ,  0, 0, 32'h0000_0000));
        send_item(make_item(FUNC_BLEND, 0, 0, 32'h0C22_3800));
        send_item(make_item(FUNC_BLEND, 0, 0, 32'h0C22_3800));
        send_item(make_item(FUNC_BLEND, 1, 0, 32'hFFFF_FFFF));
        send_item(make_item(FUNC_BLEND, 1, 0, 32'h0A14_1E80));
        send_item(make_item(FUNC_BLEND, 1, 0, 32'h5566_7700));
        send_item(make_item(FUNC_READ,  1, 0, $urandom));
        send_item(make_item(FUNC_BLEND, FB_W - 1, FB_H - 1, 32'hFF00_00FF));
        send_item(make_item(FUNC_READ,  FB_W - 1, FB_H - 1, $urandom));
        send_item(make_item(FUNC_BLEND, FB_W, 0, 32'h1234_5678));
        send_item(make_item(FUNC_BLEND, 0, FB_H, 32'h1234_5678));
        send_item(make_item(FUNC_READ,  -1, 0, 32'h0000_0000));
        send_item(make_item(FUNC_BLEND, 0, -1, 32'hFFFF_FFFF));
        send_item(make_item(FUNC_BLEND, -2048, -2048, 32'hFFFF_FFFF));
        send_item(make_item(FUNC_READ,  2047, 2047, 32'hFFFF_FFFF));
        send_item(make_item(FUNC_BLEND, 2047, 0, 32'h8080_8080));
        send_item(make_item(FUNC_BLEND, 0, 2047, 32'h8080_8080));
        send_item(make_item(FUNC_BLEND, 2, 0, 32'h0000_00FF));
        send_item(make_item(FUNC_BLEND, 2, 0, 32'hFFFF_FFFF));
        send_item(make_item(FUNC_BLEND, 2, 0, 32'hFFFF_FFFF));
        send_item(make_item(FUNC_BLEND, 3, 0, 32'hFFFF_FF01));
        send_item(make_item(FUNC_BLEND, 3, 0, 32'h0000_00FE));
        send_item(make_item(FUNC_READ,  3, 0, 32'h0000_0000));
    endtask

    // Random transactions, mostly on a small patch so that blends land on
    // pixels that already hold color.
    task automatic run_random();
        int          edge_vals [6];
        int          pick;
        int          x;
        int          y;
        logic [31:0] rgba;
        func_t       f;
        edge_vals = '{-1, 0, 1, FB_W - 1, FB_W, FB_W + 1};
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                x = $urandom_range(0, 7);
                y = $urandom_range(0, 3);
            end
            else if (pick < 70)
            begin
                x = $urandom_range(0, FB_W - 1);
                y = $urandom_range(0, FB_H - 1);
            end
            else if (pick < 80)
            begin
                x = edge_vals[$urandom_range(0, 5)];
                y = edge_vals[$urandom_range(0, 5)] - FB_W + FB_H;
            end
            else
            begin
                x = $urandom_range(0, 4095) - 2048;
                y = $urandom_range(0, 4095) - 2048;
            end
            rgba = $urandom;
            pick = $urandom_range(0, 9);
            if (pick < 2)
                rgba[7:0] = 8'h00;
            else if (pick < 4)
                rgba[7:0] = 8'hFF;
            f = ($urandom_range(0, 3) == 0) ? FUNC_READ : FUNC_BLEND;
            send_item(make_item(f, x, y, rgba));
            // Let the block run dry once in the middle of the random part.
            if (n == RANDOM_ITEMS / 2)
                drain_results();
        end
    endtask

    // Result side: take results with random stalls.
    initial
    begin
        int stall;
        pop = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (rx_calm_left == 0)
            begin
                rx_calm      = ($urandom_range(0, 2) == 0);
                rx_calm_left = $urandom_range(10, 40);
            end
            rx_calm_left = rx_calm_left - 1;
            stall = rx_calm ? 0 : $urandom_range(0, 4);
            if (stall > 0)
            begin
                pop <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pop <= 1'b1;
            do
                @(posedge clk);
            while (empty);
        end
    end

    // Reset, stimulus and verdict.
    initial
    begin
        rst_n = 1'b0;
        push  = 1'b0;
        item  = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random();
        drain_results();
        // Leave room for a stray result.
        repeat (24) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/core/fbab_pkg.sv
rtl/core/fbab_front.sv
rtl/core/fbab_queue.sv
rtl/core/fbab_back.sv
rtl/core/framebuffer_alpha_blend.sv
rtl/core/fbab_checker.sv
sim/framebuffer_alpha_blend_checker.sv
sim/framebuffer_alpha_blend_test.sv
